FILE: hw/rtl/idalloc_pkg.sv
// Shared types and constants for the identifier allocator.
`timescale 1ns / 1ps

package idalloc_pkg;

   // Fixed widths of the request and response ports.
   localparam int ID_PORT_W     = 10;
   localparam int HANDLE_PORT_W = 32;

   // Request operations; the remaining code is a no-op.
   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_LOOKUP  = 2'd2
   } opcode_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_RANGE     = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_EXEC
   } state_type;

endpackage

FILE: hw/rtl/id_allocator_with_free_stack.sv
// Identifier allocator with a handle table and a last-in first-out free stack.
`timescale 1ns / 1ps

// Usage:
// The req_ channel carries one operation per item: allocate an id and bind two
// handles to it, release an id, or look up the handles bound to an id. The rsp_
// channel returns exactly one item per request, in order.
// Each item passes through two steps: the IDLE state issues the memory read
// (handle table entry or top of the free stack) and the EXEC state evaluates,
// writes back and loads the response register. A new item is accepted only
// after the previous one has been evaluated. When the response register is
// free, the EXEC state after acceptance loads it and raises rsp_valid.
// After reset the handle table is swept to zero, one entry per cycle, over all
// NUM_IDS entries; req_ready stays low during the sweep.
// The response register holds a finished item while the receiver stalls; one
// further item is accepted meanwhile and waits with its read data until the
// response register frees up.
// Allocate reuses the most recently released id, else a fresh id counting up
// from FIRST_ID, and reports exhaustion when neither is left.
module id_allocator_with_free_stack #(
   parameter int NUM_IDS     = 1024,
   parameter int FIRST_ID    = 2,
   parameter int HANDLE_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_opcode,
   input  logic [idalloc_pkg::ID_PORT_W-1:0]      req_id,
   input  logic [idalloc_pkg::HANDLE_PORT_W-1:0]  req_primary_handle,
   input  logic [idalloc_pkg::HANDLE_PORT_W-1:0]  req_secondary_handle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [idalloc_pkg::ID_PORT_W-1:0]      rsp_result_id,
   output logic [1:0]                             rsp_status,
   output logic [idalloc_pkg::HANDLE_PORT_W-1:0]  rsp_primary_out,
   output logic [idalloc_pkg::HANDLE_PORT_W-1:0]  rsp_secondary_out
);

   localparam int IDW     = $clog2(NUM_IDS);
   localparam int FRESH_W = $clog2(NUM_IDS + 1);
   localparam int ENTRY_W = 2 * HANDLE_BITS;

   // Control state.
   idalloc_pkg::state_type state_ff, state_in;
   logic [IDW-1:0]         clr_ff, clr_in;
   logic [IDW-1:0]         stack_count_ff, stack_count_in;
   logic [FRESH_W-1:0]     fresh_ff, fresh_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Captured request.
   idalloc_pkg::opcode_type op_ff;
   logic [idalloc_pkg::ID_PORT_W-1:0] id_ff;
   logic [HANDLE_BITS-1:0]            ph_ff;
   logic [HANDLE_BITS-1:0]            sh_ff;

   // Response register.
   logic [idalloc_pkg::ID_PORT_W-1:0]     rsp_id_ff, rsp_id_in;
   idalloc_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [idalloc_pkg::HANDLE_PORT_W-1:0] rsp_pout_ff, rsp_pout_in;
   logic [idalloc_pkg::HANDLE_PORT_W-1:0] rsp_sout_ff, rsp_sout_in;
   logic                                  rsp_load;

   // Handle table: entry is {secondary, primary}.
   logic [ENTRY_W-1:0] table_mem [NUM_IDS];
   logic [ENTRY_W-1:0] table_rd_ff;
   logic               table_rd_en;
   logic [IDW-1:0]     table_rd_addr;
   logic               table_wr_en;
   logic [IDW-1:0]     table_wr_addr;
   logic [ENTRY_W-1:0] table_wr_data;

   // Free stack: holds at most NUM_IDS-1 ids.
   logic [IDW-1:0] stack_mem [NUM_IDS-1];
   logic [IDW-1:0] stack_rd_ff;
   logic           stack_rd_en;
   logic [IDW-1:0] stack_rd_addr;
   logic           stack_wr_en;
   logic [IDW-1:0] stack_wr_data;

   logic accept;
   logic out_free;
   logic id_in_range;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign id_in_range = (int'(id_ff) >= FIRST_ID) && (int'(id_ff) < NUM_IDS);

   // Next state, memory controls and response contents.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      stack_count_in = stack_count_ff;
      fresh_in       = fresh_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_load       = 1'b0;
      rsp_id_in      = id_ff;
      rsp_status_in  = idalloc_pkg::STATUS_OK;
      rsp_pout_in    = '0;
      rsp_sout_in    = '0;
      req_ready      = 1'b0;
      table_rd_en    = 1'b0;
      table_rd_addr  = IDW'(req_id);
      table_wr_en    = 1'b0;
      table_wr_addr  = clr_ff;
      table_wr_data  = '0;
      stack_rd_en    = 1'b0;
      stack_rd_addr  = stack_count_ff - IDW'(1);
      stack_wr_en    = 1'b0;
      stack_wr_data  = IDW'(id_ff);

      unique case (state_ff)
         idalloc_pkg::STATE_CLEAR: begin
            // Sweep the handle table to zero after reset.
            table_wr_en = 1'b1;
            clr_in      = clr_ff + IDW'(1);
            if (clr_ff == IDW'(NUM_IDS - 1)) begin
               state_in = idalloc_pkg::STATE_IDLE;
            end
         end
         idalloc_pkg::STATE_IDLE: begin
            // Take an item and read its table entry and the stack top.
            req_ready = 1'b1;
            if (accept) begin
               table_rd_en = 1'b1;
               stack_rd_en = (stack_count_ff != '0);
               state_in    = idalloc_pkg::STATE_EXEC;
            end
         end
         idalloc_pkg::STATE_EXEC: begin
            // Evaluate once the response register can take the result.
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = idalloc_pkg::STATE_IDLE;
               unique case (op_ff)
                  idalloc_pkg::OP_ALLOC: begin
                     table_wr_data = {sh_ff, ph_ff};
                     if (stack_count_ff != '0) begin
                        table_wr_en    = 1'b1;
                        table_wr_addr  = stack_rd_ff;
                        stack_count_in = stack_count_ff - IDW'(1);
                        rsp_id_in      = idalloc_pkg::ID_PORT_W'(stack_rd_ff);
                     end else if (fresh_ff < FRESH_W'(NUM_IDS)) begin
                        table_wr_en   = 1'b1;
                        table_wr_addr = IDW'(fresh_ff);
                        fresh_in      = fresh_ff + FRESH_W'(1);
                        rsp_id_in     = idalloc_pkg::ID_PORT_W'(fresh_ff);
                     end else begin
                        rsp_id_in     = '0;
                        rsp_status_in = idalloc_pkg::STATUS_EXHAUSTED;
                     end
                  end
                  idalloc_pkg::OP_RELEASE: begin
                     if (!id_in_range) begin
                        rsp_status_in = idalloc_pkg::STATUS_RANGE;
                     end else if (stack_count_ff == IDW'(NUM_IDS - 1)) begin
                        rsp_status_in = idalloc_pkg::STATUS_FULL;
                     end else begin
                        // Clear the primary handle, keep the secondary one.
                        rsp_pout_in    = idalloc_pkg::HANDLE_PORT_W'(
                                            table_rd_ff[HANDLE_BITS-1:0]);
                        table_wr_en    = 1'b1;
                        table_wr_addr  = IDW'(id_ff);
                        table_wr_data  = {table_rd_ff[ENTRY_W-1:HANDLE_BITS],
                                          {HANDLE_BITS{1'b0}}};
                        stack_wr_en    = 1'b1;
                        stack_count_in = stack_count_ff + IDW'(1);
                     end
                  end
                  idalloc_pkg::OP_LOOKUP: begin
                     if (!id_in_range) begin
                        rsp_status_in = idalloc_pkg::STATUS_RANGE;
                     end else begin
                        rsp_pout_in = idalloc_pkg::HANDLE_PORT_W'(
                                         table_rd_ff[HANDLE_BITS-1:0]);
                        rsp_sout_in = idalloc_pkg::HANDLE_PORT_W'(
                                         table_rd_ff[ENTRY_W-1:HANDLE_BITS]);
                     end
                  end
                  default: begin
                     // Unused opcode: echo the id and change nothing.
                  end
               endcase
            end
         end
         default: begin
            state_in = idalloc_pkg::STATE_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= idalloc_pkg::STATE_CLEAR;
         clr_ff         <= '0;
         stack_count_ff <= '0;
         fresh_ff       <= FRESH_W'(FIRST_ID);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         stack_count_ff <= stack_count_in;
         fresh_ff       <= fresh_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Capture the accepted item.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= idalloc_pkg::opcode_type'(req_opcode);
         id_ff <= req_id;
         ph_ff <= HANDLE_BITS'(req_primary_handle);
         sh_ff <= HANDLE_BITS'(req_secondary_handle);
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_id_ff     <= rsp_id_in;
         rsp_status_ff <= rsp_status_in;
         rsp_pout_ff   <= rsp_pout_in;
         rsp_sout_ff   <= rsp_sout_in;
      end
   end

   // Handle table memory with registered read.
   always_ff @(posedge clock) begin
      if (table_wr_en) begin
         table_mem[table_wr_addr] <= table_wr_data;
      end
      if (table_rd_en) begin
         table_rd_ff <= table_mem[table_rd_addr];
      end
   end

   // Free stack memory with registered read.
   always_ff @(posedge clock) begin
      if (stack_wr_en) begin
         stack_mem[stack_count_ff] <= stack_wr_data;
      end
      if (stack_rd_en) begin
         stack_rd_ff <= stack_mem[stack_rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_id     = rsp_id_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_primary_out   = rsp_pout_ff;
   assign rsp_secondary_out = rsp_sout_ff;

   // The free stack never holds more than NUM_IDS-1 ids.
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      int'(stack_count_ff) <= NUM_IDS - 1)
      else $error("free stack count out of bounds");

   // The fresh id counter stops at NUM_IDS.
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      int'(fresh_ff) <= NUM_IDS)
      else $error("fresh id counter out of bounds");

   // No response appears while the table is being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == idalloc_pkg::STATE_CLEAR) |-> !rsp_valid_ff)
      else $error("response during table clear");

   // An accepted item always moves on to evaluation.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == idalloc_pkg::STATE_EXEC))
      else $error("accepted item not evaluated");

endmodule
